// ===== hdl/ibqm_pkg.sv =====
package ibqm_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  localparam int NREGS     = 8;
  localparam int CFG_IDX_W = 4;
  localparam int REG_IDX_W = 3;
  localparam int PRE_SHIFT = 3;

  localparam logic [REG_IDX_W-1:0] REG_SRC_ORIGIN     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_EDGE       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SRC_SIDE_START = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SRC_SIDE_DELTA = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DST_ORIGIN     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DST_EDGE       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DST_SIDE_START = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DST_SIDE_DELTA = 3'd7;

  // Clock edges from the accepting edge to the edge that takes the result.
  function automatic int pipe_latency(input int frac_bits);
    return 2 * frac_bits + 56;
  endfunction

endpackage

// ===== hdl/ibqm_sqrt.sv =====
module ibqm_sqrt import ibqm_pkg::*; #(
  parameter int DW   = 64,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [DW-1:0]     in_radicand,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [DW/2-1:0]   out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int NST = DW / 2;
  localparam int QW  = DW / 2;
  localparam int RW  = QW + 4;

  logic [NST:1]    vld_r;
  logic [RW-1:0]   rem_r  [1:NST];
  logic [QW-1:0]   root_r [1:NST];
  logic [DW-1:0]   rad_r  [1:NST];
  logic [SB_W-1:0] sb_r   [1:NST];

  // One root bit per stage: bring down the next pair of radicand bits.
  for (genvar k = 1; k <= NST; k++) begin : g_stage
    logic [RW-1:0]   src_rem;
    logic [QW-1:0]   src_root;
    logic [DW-1:0]   src_rad;
    logic [SB_W-1:0] src_sb;
    logic            src_vld;
    logic [RW-1:0]   trial;
    logic [RW-1:0]   tsub;
    logic            ge;

    if (k == 1) begin : g_first
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_rad  = in_radicand;
      assign src_sb   = in_sb;
      assign src_vld  = in_valid;
    end else begin : g_next
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_rad  = rad_r[k-1];
      assign src_sb   = sb_r[k-1];
      assign src_vld  = vld_r[k-1];
    end

    assign trial = {src_rem[RW-3:0], src_rad[DW-1 -: 2]};
    assign tsub  = RW'({src_root, 2'b01});
    assign ge    = (trial >= tsub);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (trial - tsub) : trial;
      root_r[k] <= {src_root[QW-2:0], ge};
      rad_r[k]  <= src_rad << 2;
      sb_r[k]   <= src_sb;
    end
  end

  assign out_valid = vld_r[NST];
  assign out_root  = root_r[NST];
  assign out_sb    = sb_r[NST];

endmodule

// ===== hdl/ibqm_div.sv =====
module ibqm_div import ibqm_pkg::*; #(
  parameter int NUM_W     = 40,
  parameter int DEN_W     = 34,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SB_W      = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [NUM_W-1:0] in_num_a,
  input  logic signed [DEN_W-1:0] in_den_a,
  input  logic signed [NUM_W-1:0] in_num_b,
  input  logic signed [DEN_W-1:0] in_den_b,
  input  logic [SB_W-1:0]         in_sb,
  output logic                    out_valid,
  output logic signed [FRAC_BITS+4:0] out_quo_a,
  output logic signed [FRAC_BITS+4:0] out_quo_b,
  output logic [SB_W-1:0]         out_sb
);

  localparam int NB = FRAC_BITS + 4;
  localparam int QW = FRAC_BITS + 5;
  localparam int MW = 33;
  localparam int RW = ((DEN_W > MW) ? DEN_W : MW) + NB;

  localparam logic [QW-1:0]          QLIM   = QW'(8) << FRAC_BITS;
  localparam logic signed [NUM_W-1:0] NLIM  = NUM_W'(64'd1 << 32);
  localparam logic [MW-1:0]          MAGLIM = MW'(64'd1 << 32);

  logic [NB+1:0]   vld_r;
  logic [SB_W-1:0] sb_r [0:NB+1];

  logic signed [NUM_W-1:0] num_in [0:1];
  logic signed [DEN_W-1:0] den_in [0:1];
  logic signed [QW-1:0]    quo_r  [0:1];

  logic [RW-1:0]    rem_r [0:1][0:NB];
  logic [DEN_W-1:0] dm_r  [0:1][0:NB];
  logic [NB-1:0]    q_r   [0:1][0:NB];
  logic             neg_r [0:1][0:NB];
  logic             sat_r [0:1][0:NB];

  assign num_in[0] = in_num_a;
  assign num_in[1] = in_num_b;
  assign den_in[0] = in_den_a;
  assign den_in[1] = in_den_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NB:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sb_r[0] <= in_sb;
    for (int k = 1; k <= NB + 1; k++) begin
      sb_r[k] <= sb_r[k-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic          nneg;
    logic [MW-1:0] nmag;
    logic [DEN_W-1:0] dmag;
    logic          sat;
    logic [QW-1:0] mag;

    // The numerator is clamped to +-2^32 before it is scaled.
    assign nneg = num_in[l][NUM_W-1];
    assign nmag = nneg ? ((num_in[l] < -NLIM) ? MAGLIM : MW'(-num_in[l]))
                       : ((num_in[l] > NLIM) ? MAGLIM : MW'(num_in[l]));
    assign dmag = den_in[l][DEN_W-1] ? DEN_W'(-den_in[l]) : DEN_W'(den_in[l]);
    assign sat  = (nmag != '0) &&
                  ((dmag == '0) || (RW'(nmag) >= (RW'(dmag) << 4)));

    always_ff @(posedge clk) begin
      rem_r[l][0] <= RW'(nmag) << FRAC_BITS;
      dm_r[l][0]  <= dmag;
      q_r[l][0]   <= '0;
      neg_r[l][0] <= nneg ^ den_in[l][DEN_W-1];
      sat_r[l][0] <= sat;
    end

    for (genvar k = 1; k <= NB; k++) begin : g_bit
      logic [RW-1:0] dsh;
      logic          ge;

      assign dsh = RW'(dm_r[l][k-1]) << (NB - k);
      assign ge  = (rem_r[l][k-1] >= dsh);

      always_ff @(posedge clk) begin
        rem_r[l][k] <= ge ? (rem_r[l][k-1] - dsh) : rem_r[l][k-1];
        dm_r[l][k]  <= dm_r[l][k-1];
        q_r[l][k]   <= q_r[l][k-1] | (ge ? (NB'(1) << (NB - k)) : NB'(0));
        neg_r[l][k] <= neg_r[l][k-1];
        sat_r[l][k] <= sat_r[l][k-1];
      end
    end

    assign mag = sat_r[l][NB] ? QLIM
               : ((QW'(q_r[l][NB]) > QLIM) ? QLIM : QW'(q_r[l][NB]));

    always_ff @(posedge clk) begin
      quo_r[l] <= neg_r[l][NB] ? -$signed(mag) : $signed(mag);
    end
  end

  assign out_valid = vld_r[NB+1];
  assign out_sb    = sb_r[NB+1];
  assign out_quo_a = quo_r[0];
  assign out_quo_b = quo_r[1];

endmodule

// ===== hdl/inverse_bilinear_quad_mapper_unit.sv =====
// Each item passes through the 32-stage square root and then the two FRAC_BITS+6 stage dividers
// in series before its result strobe.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// Reset (synchronous, rst_n low) clears the quad registers, the cross terms and all valid bits.
// Cross terms follow a configuration write in the next cycle.
module inverse_bilinear_quad_mapper_unit import ibqm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_mapped_x,
  output logic signed [COORD_BITS-1:0] out_mapped_y,
  output logic                         out_mapped,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [31:0]                  cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int PW    = (CB > 16) ? CB : 16;
  localparam int QW    = F + 5;
  localparam int NUM_W = 40;
  localparam int DEN_W = 34;
  localparam int PA_W  = 29 + QW;
  localparam int WW    = QW + 16;
  localparam int AW    = 2 * QW + 18;

  localparam longint unsigned AREA_EPS =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;
  localparam logic signed [QW-1:0] UV_ONE = QW'(1) << F;
  localparam logic signed [PW-1:0] PMAX   = PW'(32767);
  localparam logic signed [PW-1:0] PMIN   = ~PMAX;
  localparam logic signed [AW-1:0] RND    = AW'(1) <<< (F - 1);
  localparam logic signed [AW-1:0] OMAX   = (AW'(1) <<< (CB - 1)) - AW'(1);
  localparam logic signed [AW-1:0] OMIN   = ~OMAX;

  typedef struct packed {
    logic               neg;
    logic signed [31:0] bs;
    logic signed [30:0] cx;
    logic signed [30:0] cc;
    logic signed [30:0] ce;
  } sq_sb_t;

  typedef struct packed {
    logic               neg;
    logic signed [30:0] cx;
    logic signed [30:0] ce;
  } d1_sb_t;

  typedef struct packed {
    logic               neg;
    logic signed [QW-1:0] ua;
    logic signed [QW-1:0] ub;
  } d2_sb_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  // ---------------- configuration ----------------
  logic [31:0] cfg_r [0:NREGS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NREGS))) begin
      cfg_r[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  logic signed [15:0] so_x, so_y, su_x, su_y, sv1_x, sv1_y, sv21_x, sv21_y;
  assign so_x   = $signed(cfg_r[REG_SRC_ORIGIN][15:0]);
  assign so_y   = $signed(cfg_r[REG_SRC_ORIGIN][31:16]);
  assign su_x   = $signed(cfg_r[REG_SRC_EDGE][15:0]);
  assign su_y   = $signed(cfg_r[REG_SRC_EDGE][31:16]);
  assign sv1_x  = $signed(cfg_r[REG_SRC_SIDE_START][15:0]);
  assign sv1_y  = $signed(cfg_r[REG_SRC_SIDE_START][31:16]);
  assign sv21_x = $signed(cfg_r[REG_SRC_SIDE_DELTA][15:0]);
  assign sv21_y = $signed(cfg_r[REG_SRC_SIDE_DELTA][31:16]);

  logic signed [31:0] t_a1, t_a2, t_b1, t_b2, t_o1, t_o2;
  logic signed [32:0] t_a, t_b, t_o;
  assign t_a1 = su_x * sv21_y;
  assign t_a2 = su_y * sv21_x;
  assign t_b1 = sv1_x * sv21_y;
  assign t_b2 = sv1_y * sv21_x;
  assign t_o1 = su_y * sv1_x;
  assign t_o2 = su_x * sv1_y;
  assign t_a  = t_a1 - t_a2;
  assign t_b  = t_b1 - t_b2;
  assign t_o  = t_o1 - t_o2;

  logic signed [31:0] edge_cross_r, side_cross_r, offset_cross_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_cross_r   <= '0;
      side_cross_r   <= '0;
      offset_cross_r <= '0;
    end else begin
      edge_cross_r   <= sat33(t_a);
      side_cross_r   <= sat33(t_b);
      offset_cross_r <= sat33(t_o);
    end
  end

  logic signed [32:0] a_ext, b_ext, a_abs, b_abs;
  logic               a_small, b_small, para;
  logic signed [28:0] as_s, bs_s, b1_s;
  assign a_ext   = edge_cross_r;
  assign b_ext   = side_cross_r;
  assign a_abs   = a_ext[32] ? -a_ext : a_ext;
  assign b_abs   = b_ext[32] ? -b_ext : b_ext;
  assign a_small = {31'b0, a_abs} < AREA_EPS;
  assign b_small = {31'b0, b_abs} < AREA_EPS;
  assign para    = a_small && b_small;
  assign as_s    = 29'(edge_cross_r >>> PRE_SHIFT);
  assign bs_s    = 29'(side_cross_r >>> PRE_SHIFT);
  assign b1_s    = 29'(offset_cross_r >>> PRE_SHIFT);

  // ---------------- valid chain ----------------
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, m1_v_r, m2_v_r, out_valid_r;
  logic sq_v, d1_v, d2_v;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      m1_v_r      <= 1'b0;
      m2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= start && !busy;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= sq_v;
      v6_r        <= d1_v;
      v7_r        <= v6_r;
      v8_r        <= d2_v;
      m1_v_r      <= v8_r;
      m2_v_r      <= m1_v_r;
      out_valid_r <= m2_v_r;
    end
  end

  // ---------------- point offset ----------------
  logic signed [PW-1:0] px_w, py_w;
  logic signed [15:0]   px_c, py_c;
  logic signed [16:0]   d_x_nxt, d_y_nxt, d_x_r, d_y_r;

  assign px_w    = in_point_x;
  assign py_w    = in_point_y;
  assign px_c    = (px_w > PMAX) ? 16'sh7FFF : ((px_w < PMIN) ? 16'sh8000 : 16'(px_w));
  assign py_c    = (py_w > PMAX) ? 16'sh7FFF : ((py_w < PMIN) ? 16'sh8000 : 16'(py_w));
  assign d_x_nxt = px_c - so_x;
  assign d_y_nxt = py_c - so_y;

  always_ff @(posedge clk) begin
    d_x_r <= d_x_nxt;
    d_y_r <= d_y_nxt;
  end

  // ---------------- cross products with the point ----------------
  logic signed [32:0] p_cx1, p_cx2, p_cc1, p_cc2, p_ce1, p_ce2;
  logic signed [33:0] cx_r, cc_r, ce_r;
  assign p_cx1 = d_x_r * sv21_y;
  assign p_cx2 = d_y_r * sv21_x;
  assign p_cc1 = sv1_y * d_x_r;
  assign p_cc2 = sv1_x * d_y_r;
  assign p_ce1 = su_y * d_x_r;
  assign p_ce2 = su_x * d_y_r;

  always_ff @(posedge clk) begin
    cx_r <= p_cx1 - p_cx2;
    cc_r <= p_cc1 - p_cc2;
    ce_r <= p_ce1 - p_ce2;
  end

  // ---------------- pre-shift ----------------
  logic signed [34:0] bsum;
  logic signed [31:0] bs2_r;
  logic signed [30:0] cx2_r, cc2_r, ce2_r;
  assign bsum = offset_cross_r + cx_r;

  always_ff @(posedge clk) begin
    bs2_r <= 32'(bsum >>> PRE_SHIFT);
    cx2_r <= 31'(cx_r >>> PRE_SHIFT);
    cc2_r <= 31'(cc_r >>> PRE_SHIFT);
    ce2_r <= 31'(ce_r >>> PRE_SHIFT);
  end

  // ---------------- discriminant products ----------------
  logic signed [63:0] bb_r;
  logic signed [59:0] ac_r;
  logic signed [63:0] bb_nxt;
  logic signed [59:0] ac_nxt;
  logic signed [31:0] bs3_r;
  logic signed [30:0] cx3_r, cc3_r, ce3_r;
  assign bb_nxt = bs2_r * bs2_r;
  assign ac_nxt = as_s * cc2_r;

  always_ff @(posedge clk) begin
    bb_r  <= bb_nxt;
    ac_r  <= ac_nxt;
    bs3_r <= bs2_r;
    cx3_r <= cx2_r;
    cc3_r <= cc2_r;
    ce3_r <= ce2_r;
  end

  logic signed [63:0] ac_ext, disc_r;
  sq_sb_t             s4_r;
  assign ac_ext = ac_r;

  always_ff @(posedge clk) begin
    disc_r   <= bb_r + (ac_ext <<< 2);
    s4_r.neg <= 1'b0;
    s4_r.bs  <= bs3_r;
    s4_r.cx  <= cx3_r;
    s4_r.cc  <= cc3_r;
    s4_r.ce  <= ce3_r;
  end

  // ---------------- square root ----------------
  sq_sb_t      sq_in_sb, sq_out_sb;
  logic [31:0] det;
  logic [$bits(sq_sb_t)-1:0] sq_out_bits;

  always_comb begin
    sq_in_sb     = s4_r;
    sq_in_sb.neg = disc_r[63];
  end

  ibqm_sqrt #(
    .DW   (64),
    .SB_W ($bits(sq_sb_t))
  ) u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v4_r),
    .in_radicand (disc_r[63] ? 64'd0 : disc_r),
    .in_sb       (sq_in_sb),
    .out_valid   (sq_v),
    .out_root    (det),
    .out_sb      (sq_out_bits)
  );

  assign sq_out_sb = sq_out_bits;

  // ---------------- first division operands ----------------
  logic signed [NUM_W-1:0] bs_e, det_e, cc_e, num_a_nxt, num_b_nxt, num_a_r, num_b_r;
  logic signed [DEN_W-1:0] as_d, den_gen, den_a_nxt, den_a_r, den_b_r;
  d1_sb_t                  d1_in_r, d1_out;
  logic [$bits(d1_sb_t)-1:0] d1_out_bits;

  assign bs_e    = sq_out_sb.bs;
  assign det_e   = NUM_W'(det);
  assign cc_e    = sq_out_sb.cc;
  assign as_d    = as_s;
  assign den_gen = -(as_d <<< 1);

  always_comb begin
    if (para) begin
      num_a_nxt = cc_e;
      den_a_nxt = -DEN_W'(b1_s);
    end else if (a_small) begin
      num_a_nxt = -cc_e;
      den_a_nxt = DEN_W'(sq_out_sb.bs);
    end else begin
      num_a_nxt = det_e - bs_e;
      den_a_nxt = den_gen;
    end
  end
  assign num_b_nxt = -bs_e - det_e;

  always_ff @(posedge clk) begin
    num_a_r    <= num_a_nxt;
    den_a_r    <= den_a_nxt;
    num_b_r    <= num_b_nxt;
    den_b_r    <= den_gen;
    d1_in_r.neg <= sq_out_sb.neg;
    d1_in_r.cx  <= sq_out_sb.cx;
    d1_in_r.ce  <= sq_out_sb.ce;
  end

  logic signed [QW-1:0] ua, ub;

  ibqm_div #(
    .NUM_W     (NUM_W),
    .DEN_W     (DEN_W),
    .FRAC_BITS (F),
    .SB_W      ($bits(d1_sb_t))
  ) u_div_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_num_a  (num_a_r),
    .in_den_a  (den_a_r),
    .in_num_b  (num_b_r),
    .in_den_b  (den_b_r),
    .in_sb     (d1_in_r),
    .out_valid (d1_v),
    .out_quo_a (ua),
    .out_quo_b (ub),
    .out_sb    (d1_out_bits)
  );

  assign d1_out = d1_out_bits;

  // ---------------- second division operands ----------------
  logic signed [PA_W-1:0] pa_nxt, pb_nxt, pa_r, pb_r;
  logic signed [QW-1:0]   ua6_r, ub6_r;
  d1_sb_t                 s6_r;
  assign pa_nxt = as_s * ua;
  assign pb_nxt = as_s * ub;

  always_ff @(posedge clk) begin
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    ua6_r <= ua;
    ub6_r <= ub;
    s6_r  <= d1_out;
  end

  logic signed [NUM_W-1:0] cx_e, ce_e, pa_sh, pb_sh;
  logic signed [NUM_W-1:0] nva_r, nvb_r;
  logic signed [DEN_W-1:0] dva_r, dvb_r;
  d2_sb_t                  d2_in_r, d2_out;
  logic [$bits(d2_sb_t)-1:0] d2_out_bits;

  assign cx_e  = s6_r.cx;
  assign ce_e  = s6_r.ce;
  assign pa_sh = NUM_W'(pa_r >>> F);
  assign pb_sh = NUM_W'(pb_r >>> F);

  always_ff @(posedge clk) begin
    nva_r      <= para ? ce_e : (cx_e - pa_sh);
    dva_r      <= para ? DEN_W'(b1_s) : DEN_W'(bs_s);
    nvb_r      <= cx_e - pb_sh;
    dvb_r      <= DEN_W'(bs_s);
    d2_in_r.neg <= s6_r.neg;
    d2_in_r.ua  <= ua6_r;
    d2_in_r.ub  <= ub6_r;
  end

  logic signed [QW-1:0] va, vb;

  ibqm_div #(
    .NUM_W     (NUM_W),
    .DEN_W     (DEN_W),
    .FRAC_BITS (F),
    .SB_W      ($bits(d2_sb_t))
  ) u_div_v (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v7_r),
    .in_num_a  (nva_r),
    .in_den_a  (dva_r),
    .in_num_b  (nvb_r),
    .in_den_b  (dvb_r),
    .in_sb     (d2_in_r),
    .out_valid (d2_v),
    .out_quo_a (va),
    .out_quo_b (vb),
    .out_sb    (d2_out_bits)
  );

  assign d2_out = d2_out_bits;

  // ---------------- root choice ----------------
  // The first root wins when the edge area is small or when it lies strictly inside the unit square.
  logic                 in_square;
  logic signed [QW-1:0] u_r, v_r;
  logic                 neg8_r;
  assign in_square = (d2_out.ua > 0) && (d2_out.ua < UV_ONE) && (va > 0) && (va < UV_ONE);

  always_ff @(posedge clk) begin
    neg8_r <= d2_out.neg;
    if (a_small || in_square) begin
      u_r <= d2_out.ua;
      v_r <= va;
    end else begin
      u_r <= d2_out.ub;
      v_r <= vb;
    end
  end

  // ---------------- destination bilinear form ----------------
  logic signed [QW-1:0] u1_r;
  logic                 neg1_r, neg2_r, mapped_r;
  logic signed [CB-1:0] res_r [0:1];

  always_ff @(posedge clk) begin
    u1_r     <= u_r;
    neg1_r   <= neg8_r;
    neg2_r   <= neg1_r;
    mapped_r <= !neg2_r;
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic signed [15:0]   d_o, d_e, d_s1, d_s21;
    logic signed [WW-1:0] pw_nxt, pe_nxt, ps_nxt, pw_r, pe_r, ps_r, w_v;
    logic signed [WW:0]   pes_nxt, pes_r;
    logic signed [AW-1:0] puw_nxt, puw_r, acc, rnd, r;

    assign d_o   = $signed(cfg_r[REG_DST_ORIGIN][16*a +: 16]);
    assign d_e   = $signed(cfg_r[REG_DST_EDGE][16*a +: 16]);
    assign d_s1  = $signed(cfg_r[REG_DST_SIDE_START][16*a +: 16]);
    assign d_s21 = $signed(cfg_r[REG_DST_SIDE_DELTA][16*a +: 16]);

    assign pw_nxt = v_r * d_s21;
    assign pe_nxt = u_r * d_e;
    assign ps_nxt = v_r * d_s1;

    always_ff @(posedge clk) begin
      pw_r <= pw_nxt;
      pe_r <= pe_nxt;
      ps_r <= ps_nxt;
    end

    assign w_v     = pw_r >>> F;
    assign puw_nxt = u1_r * w_v;
    assign pes_nxt = pe_r + ps_r;

    always_ff @(posedge clk) begin
      puw_r <= puw_nxt;
      pes_r <= pes_nxt;
    end

    assign acc = puw_r + pes_r;
    assign rnd = (acc + RND) >>> F;
    assign r   = d_o + rnd;

    always_ff @(posedge clk) begin
      if (neg2_r) begin
        res_r[a] <= '0;
      end else if (r > OMAX) begin
        res_r[a] <= CB'(OMAX);
      end else if (r < OMIN) begin
        res_r[a] <= CB'(OMIN);
      end else begin
        res_r[a] <= CB'(r);
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_mapped_x = res_r[0];
  assign out_mapped_y = res_r[1];
  assign out_mapped   = mapped_r;

endmodule

// ===== hdl/ibqm_checker.sv =====
module ibqm_checker import ibqm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic signed [COORD_BITS-1:0] out_mapped_x,
  input logic signed [COORD_BITS-1:0] out_mapped_y,
  input logic                         out_mapped
);

  localparam int LAT = pipe_latency(FRAC_BITS);

  // Every result strobe traces back to an item accepted a fixed latency earlier.
  a_strobe_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching item");

  // An unmapped point reports the origin.
  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_mapped) |-> (out_mapped_x == '0 && out_mapped_y == '0))
    else $error("unmapped result carries nonzero coordinates");

  a_reset_flush: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result strobe right after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("pipeline refused an item");

endmodule

bind inverse_bilinear_quad_mapper_unit ibqm_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_ibqm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_mapped_x (out_mapped_x),
  .out_mapped_y (out_mapped_y),
  .out_mapped   (out_mapped)
);

// ===== tb/sv/inverse_bilinear_quad_mapper_unit_tb.sv =====
`timescale 1ns / 1ps

module inverse_bilinear_quad_mapper_unit_tb;
  import ibqm_pkg::*;

  localparam int       FRAC      = FRAC_BITS_DEF;
  localparam longint   ONE_UV    = longint'(1) << FRAC;
  localparam longint   UV_SAT    = longint'(8) << FRAC;
  localparam longint   NUM_SAT   = longint'(1) << 32;
  localparam longint   AREA_MIN  = ((longint'(1) << (2 * FRAC)) + 5000) / 10000;
  localparam int       WATCHDOG  = 4000;
  localparam int       PHASES    = 12;
  localparam int       PER_PHASE = 170;

  typedef enum int {SET_RESET, SET_SQUARE, SET_GENERAL, SET_TRAPEZOID, SET_EXTREME,
                    SET_RANDOM} quad_kind_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               ok;
  } mapped_t;

  typedef struct {
    quad_kind_t         kind;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               known;
    mapped_t            result;
  } point_row_t;

  typedef logic [31:0] quad_set_t [NREGS];

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic signed [15:0]  in_point_x = '0;
  logic signed [15:0]  in_point_y = '0;
  logic                out_valid;
  logic signed [15:0]  out_mapped_x;
  logic signed [15:0]  out_mapped_y;
  logic                out_mapped;
  logic                cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]         cfg_data = '0;

  logic [31:0] quad_reg [NREGS];
  longint      edge_area, side_area, offset_area;
  mapped_t     pending_q [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  always #2 clk = ~clk;

  inverse_bilinear_quad_mapper_unit DUT (
    .clk, .rst_n, .start, .busy, .in_point_x, .in_point_y,
    .out_valid, .out_mapped_x, .out_mapped_y, .out_mapped,
    .cfg_we, .cfg_index, .cfg_data
  );

  function automatic longint lo16(input logic [31:0] r);
    return longint'($signed(r[15:0]));
  endfunction

  function automatic longint hi16(input logic [31:0] r);
    return longint'($signed(r[31:16]));
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint ratio(input longint num, input longint den);
    longint n;
    n = clip(num, -NUM_SAT, NUM_SAT);
    if (den == 0) return n > 0 ? UV_SAT : (n < 0 ? -UV_SAT : 0);
    return clip((n * ONE_UV) / den, -UV_SAT, UV_SAT);
  endfunction

  function automatic longint int_root(input longint v);
    longint unsigned rem, res, bitv;
    rem = v;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [15:0] warp_axis(input longint o, e, s1, s21, u, v);
    longint w, acc;
    w = (v * s21) >>> FRAC;
    acc = u * e + v * s1 + u * w;
    return 16'(clip(o + ((acc + (longint'(1) << (FRAC - 1))) >>> FRAC), -32768, 32767));
  endfunction

  // Stores a register write and refreshes the three cross-product areas.
  task automatic model_write(input int idx, input logic [31:0] val);
    longint ux, uy, v1x, v1y, dx, dy;
    if (idx >= NREGS) return;
    quad_reg[idx] = val;
    ux = lo16(quad_reg[REG_SRC_EDGE]);        uy = hi16(quad_reg[REG_SRC_EDGE]);
    v1x = lo16(quad_reg[REG_SRC_SIDE_START]); v1y = hi16(quad_reg[REG_SRC_SIDE_START]);
    dx = lo16(quad_reg[REG_SRC_SIDE_DELTA]);  dy = hi16(quad_reg[REG_SRC_SIDE_DELTA]);
    edge_area = clip(ux * dy - uy * dx, -(longint'(1) << 31), (longint'(1) << 31) - 1);
    side_area = clip(v1x * dy - v1y * dx, -(longint'(1) << 31), (longint'(1) << 31) - 1);
    offset_area = clip(uy * v1x - ux * v1y, -(longint'(1) << 31), (longint'(1) << 31) - 1);
  endtask

  function automatic mapped_t map_point(input logic signed [15:0] px, py);
    mapped_t r;
    longint ux, uy, v1x, v1y, dlx, dly, offx, offy;
    longint as, bsh, b1s, cs, bq, cq, disc, root, den, u, v, cr;
    ux = lo16(quad_reg[REG_SRC_EDGE]);        uy = hi16(quad_reg[REG_SRC_EDGE]);
    v1x = lo16(quad_reg[REG_SRC_SIDE_START]); v1y = hi16(quad_reg[REG_SRC_SIDE_START]);
    dlx = lo16(quad_reg[REG_SRC_SIDE_DELTA]); dly = hi16(quad_reg[REG_SRC_SIDE_DELTA]);
    offx = longint'(px) - lo16(quad_reg[REG_SRC_ORIGIN]);
    offy = longint'(py) - hi16(quad_reg[REG_SRC_ORIGIN]);
    cr = offx * dly - offy * dlx;
    as = edge_area >>> PRE_SHIFT;
    bsh = side_area >>> PRE_SHIFT;
    b1s = offset_area >>> PRE_SHIFT;
    cs = cr >>> PRE_SHIFT;
    bq = (offset_area + cr) >>> PRE_SHIFT;
    cq = (v1y * offx - v1x * offy) >>> PRE_SHIFT;
    disc = bq * bq + 4 * as * cq;
    r = '{x: '0, y: '0, ok: 1'b0};
    if (disc < 0) return r;
    if ((edge_area < 0 ? -edge_area : edge_area) < AREA_MIN) begin
      if ((side_area < 0 ? -side_area : side_area) < AREA_MIN) begin
        u = ratio(cq, -b1s);
        v = ratio((uy * offx - ux * offy) >>> PRE_SHIFT, b1s);
      end else begin
        u = ratio(-cq, bq);
        v = ratio(cs - ((as * u) >>> FRAC), bsh);
      end
    end else begin
      root = int_root(disc);
      den = -2 * as;
      u = ratio(-bq + root, den);
      v = ratio(cs - ((as * u) >>> FRAC), bsh);
      // The plus root is kept only when it lands strictly inside the unit square.
      if (!(u > 0 && u < ONE_UV && v > 0 && v < ONE_UV)) begin
        u = ratio(-bq - root, den);
        v = ratio(cs - ((as * u) >>> FRAC), bsh);
      end
    end
    r.x = warp_axis(lo16(quad_reg[REG_DST_ORIGIN]), lo16(quad_reg[REG_DST_EDGE]),
                    lo16(quad_reg[REG_DST_SIDE_START]), lo16(quad_reg[REG_DST_SIDE_DELTA]),
                    u, v);
    r.y = warp_axis(hi16(quad_reg[REG_DST_ORIGIN]), hi16(quad_reg[REG_DST_EDGE]),
                    hi16(quad_reg[REG_DST_SIDE_START]), hi16(quad_reg[REG_DST_SIDE_DELTA]),
                    u, v);
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] pack_xy(input int x, input int y);
    return {y[15:0], x[15:0]};
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [31:0] corner_word();
    logic [15:0] pick [4];
    pick = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
    return {pick[$urandom_range(0, 3)], pick[$urandom_range(0, 3)]};
  endfunction

  function automatic quad_set_t make_set(input quad_kind_t kind, input bit vary);
    quad_set_t s;
    int d;
    d = vary ? jitter(4096) : 4096;
    s[REG_SRC_ORIGIN] = vary ? pack_xy(jitter(8192), jitter(8192)) : '0;
    s[REG_SRC_EDGE] = pack_xy(16384 + (vary ? jitter(2048) : 0), vary ? jitter(2048) : 0);
    s[REG_SRC_SIDE_START] = pack_xy(vary ? jitter(2048) : 0, 16384 + (vary ? jitter(2048) : 0));
    s[REG_DST_ORIGIN] = pack_xy(vary ? jitter(8192) : 1024, vary ? jitter(8192) : -1024);
    s[REG_DST_EDGE] = pack_xy(vary ? jitter(16384) : 8192, vary ? jitter(16384) : 2048);
    s[REG_DST_SIDE_START] = pack_xy(vary ? jitter(16384) : -2048, vary ? jitter(16384) : 8192);
    s[REG_DST_SIDE_DELTA] = pack_xy(vary ? jitter(4096) : 1000, vary ? jitter(4096) : -500);
    case (kind)
      SET_RESET: s = '{default: '0};
      SET_SQUARE: s[REG_SRC_SIDE_DELTA] = '0;
      SET_GENERAL: s[REG_SRC_SIDE_DELTA] = pack_xy(d, vary ? jitter(4096) : 4096);
      SET_TRAPEZOID: begin
        // A side delta along a pure x edge leaves the edge area at zero.
        s[REG_SRC_EDGE] = pack_xy(16384, 0);
        s[REG_SRC_SIDE_DELTA] = pack_xy(d == 0 ? 1 : d, 0);
      end
      SET_EXTREME: begin
        if (vary) begin
          foreach (s[i]) s[i] = corner_word();
        end else begin
          s = '{32'h8000_8000, 32'h7FFF_7FFF, 32'h7FFF_8000, 32'h8000_7FFF,
                32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF};
        end
      end
      default: foreach (s[i]) s[i] = $urandom;
    endcase
    return s;
  endfunction

  // Writes all registers back to back, plus one write to an unused index.
  task automatic program_quads(input quad_set_t s);
    for (int i = 0; i <= NREGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= (i < NREGS) ? CFG_IDX_W'(i) : CFG_IDX_W'(NREGS + $urandom_range(0, 7));
      cfg_data <= (i < NREGS) ? s[i] : $urandom;
      @(posedge clk);
      if (i < NREGS) model_write(i, s[i]);
    end
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_point(input logic signed [15:0] x, y, input logic known,
                            input mapped_t result);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
    end
    start <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    do @(posedge clk); while (busy);
    pending_q.insert(pending_q.size(), known ? result : map_point(x, y));
    burst_left--;
  endtask

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    mapped_t e;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= ((start && !busy) || out_valid) ? 0 : idle_cycles + 1;
      if (out_valid) begin
        if (pending_q.size() == 0) begin
          report("result with no item outstanding");
        end else begin
          e = pending_q.pop_front();
          if (out_mapped !== e.ok)
            report($sformatf("mapped %b, expected %b", out_mapped, e.ok));
          if (out_mapped_x !== e.x)
            report($sformatf("mapped_x %0d, expected %0d", out_mapped_x, e.x));
          if (out_mapped_y !== e.y)
            report($sformatf("mapped_y %0d, expected %0d", out_mapped_y, e.y));
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("inverse_bilinear_quad_mapper_unit_tb failed");
        $finish;
      end
    end
  end

  initial begin
    point_row_t rows [$];
    mapped_t    origin_hit;
    quad_kind_t kind;
    quad_kind_t cur;
    logic signed [15:0] x, y;
    int ox, oy;

    origin_hit = '{x: '0, y: '0, ok: 1'b1};
    // With every register cleared, every division is zero over zero.
    rows.insert(rows.size(), '{SET_RESET, 16'sh0000, 16'sh0000, 1'b1, origin_hit});
    rows.insert(rows.size(), '{SET_RESET, 16'sh7FFF, 16'sh7FFF, 1'b1, origin_hit});
    rows.insert(rows.size(), '{SET_RESET, -16'sh8000, -16'sh8000, 1'b1, origin_hit});
    rows.insert(rows.size(), '{SET_RESET, 16'sh7FFF, -16'sh8000, 1'b1, origin_hit});
    rows.insert(rows.size(), '{SET_SQUARE, 16'sh2000, 16'sh2000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_SQUARE, 16'sh0000, 16'sh4000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_SQUARE, 16'sh7FFF, -16'sh8000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_SQUARE, -16'sh8000, 16'sh7FFF, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_GENERAL, 16'sh2000, 16'sh2000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_GENERAL, 16'sh4000, 16'sh0000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_GENERAL, -16'sh4000, 16'sh7000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_GENERAL, 16'sh7FFF, -16'sh8000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_GENERAL, -16'sh8000, -16'sh8000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_TRAPEZOID, 16'sh1000, 16'sh3000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_TRAPEZOID, 16'sh7FFF, 16'sh7FFF, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_TRAPEZOID, -16'sh8000, 16'sh0000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_EXTREME, 16'sh7FFF, 16'sh7FFF, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_EXTREME, -16'sh8000, -16'sh8000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_EXTREME, 16'sh0000, 16'sh0000, 1'b0, origin_hit});
    rows.insert(rows.size(), '{SET_EXTREME, 16'sh7FFF, -16'sh8000, 1'b0, origin_hit});

    foreach (quad_reg[i]) quad_reg[i] = '0;
    edge_area = 0;
    side_area = 0;
    offset_area = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur = SET_RESET;
    foreach (rows[i]) begin
      if (rows[i].kind != cur) begin
        drain();
        cur = rows[i].kind;
        program_quads(make_set(cur, 1'b0));
      end
      send_point(rows[i].px, rows[i].py, rows[i].known, rows[i].result);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      kind = quad_kind_t'(ph % 6);
      program_quads(make_set(kind, 1'b1));
      ox = int'(lo16(quad_reg[REG_SRC_ORIGIN]));
      oy = int'(hi16(quad_reg[REG_SRC_ORIGIN]));
      for (int n = 0; n < PER_PHASE; n++) begin
        // In square, general and trapezoid sets most points land in or near the source quad; others are arbitrary.
        if (kind inside {SET_SQUARE, SET_GENERAL, SET_TRAPEZOID} &&
            $urandom_range(0, 4) != 0) begin
          x = 16'(ox + int'($urandom_range(0, 20000)) - 2000);
          y = 16'(oy + int'($urandom_range(0, 20000)) - 2000);
        end else begin
          x = 16'($urandom);
          y = 16'($urandom);
        end
        send_point(x, y, 1'b0, origin_hit);
      end
    end

    drain();
    repeat (pipe_latency(FRAC) + 10) @(posedge clk);
    if (errors == 0)
      $display("inverse_bilinear_quad_mapper_unit_tb passed");
    else
      $display("inverse_bilinear_quad_mapper_unit_tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ibqm_pkg.sv
hdl/ibqm_sqrt.sv
hdl/ibqm_div.sv
hdl/inverse_bilinear_quad_mapper_unit.sv
hdl/ibqm_checker.sv
tb/sv/inverse_bilinear_quad_mapper_unit_tb.sv
